@@ design/tlc_pkg.sv @@
// tlc_pkg: shared types and constants for the three level cache lookup
// no dependencies
`timescale 1ns / 1ps
package tlc_pkg;
  localparam int AGE_W = 16;
  localparam logic [AGE_W-1:0] AGE_MAX = '1;
  localparam int CFG_IDX_W = 4;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POLICY  = 4'd0,
    REG_BOFF    = 4'd1,
    REG_L1_SETS = 4'd2,
    REG_L1_WAYS = 4'd3,
    REG_L2_SETS = 4'd4,
    REG_L2_WAYS = 4'd5,
    REG_L3_SETS = 4'd6,
    REG_L3_WAYS = 4'd7
  } cfg_reg_t;

  localparam logic [1:0] LVL_MISS = 2'd3;

  // level configuration and probe response
  typedef struct packed {
    logic       policy;
    logic [3:0] boff;
    logic [3:0] set_bits;
    logic [3:0] ways;
  } lvl_cfg_t;

  typedef struct packed {
    logic done;
    logic hit;
  } lvl_rsp_t;

  function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
    age_inc = (a == AGE_MAX) ? a : a + 1'b1;
  endfunction
endpackage

@@ design/tlc_level.sv @@
// tlc_level: one set-associative level, one set wide memory, read modify write
// depends on tlc_pkg
`timescale 1ns / 1ps
module tlc_level import tlc_pkg::*; #(
  parameter int SETS = 64,
  parameter int WAYS = 8,
  parameter int ADDR_BITS = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [ADDR_BITS-1:0] addr,
  input  lvl_cfg_t             cfg,
  output lvl_rsp_t             rsp,
  output logic                 init_done
);
  localparam int SET_W = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int WCNT_W = $clog2(WAYS + 1);

  typedef struct packed {
    logic                 vld;
    logic [ADDR_BITS-1:0] tag;
    logic [AGE_W-1:0]     fill;
    logic [AGE_W-1:0]     use_age;
  } line_t;
  typedef line_t [WAYS-1:0] set_line_t;

  // valid bits, tags and ages in memory, cleared one set per cycle after reset
  set_line_t        mem [SETS];
  set_line_t        rd_r;
  logic [SET_W-1:0] set_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic [WCNT_W-1:0] nways_r;
  logic             rd_pend_r;
  logic [SET_W-1:0] clr_idx_r;
  logic             clr_busy_r;

  logic [3:0] b;
  logic [SET_W-1:0] set_c;
  logic [ADDR_BITS-1:0] tag_c;
  logic [WCNT_W-1:0] nways_c;

  always_comb begin
    b = cfg.set_bits;
    for (int i = 0; i < 16; i++)
      if (b > 0 && (64'd1 << b) > 64'(SETS)) b = b - 4'd1;
    set_c = SET_W'((addr >> cfg.boff) & ((ADDR_BITS'(1) << b) - 1'b1));
    tag_c = addr >> (5'(cfg.boff) + 5'(b));
    if (cfg.ways == 0) nways_c = WCNT_W'(1);
    else if (32'(cfg.ways) > WAYS) nways_c = WCNT_W'(WAYS);
    else nways_c = WCNT_W'(cfg.ways);
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rd_r    <= mem[set_c];
      set_r   <= set_c;
      tag_r   <= tag_c;
      nways_r <= nways_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) rd_pend_r <= 1'b0;
    else rd_pend_r <= start;
  end

  // clearing pass over all SETS sets after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_idx_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_idx_r == SET_W'(SETS - 1)) clr_busy_r <= 1'b0;
      clr_idx_r <= clr_idx_r + 1'b1;
    end
  end

  assign init_done = !clr_busy_r;

  // compare and victim choice on the registered set
  logic [WAYS-1:0] vset;
  logic hit;
  logic [WAY_W-1:0] hway, pick;
  logic found;
  logic [AGE_W-1:0] best, a;
  set_line_t wr;

  always_comb begin
    for (int w = 0; w < WAYS; w++) vset[w] = rd_r[w].vld;
    hit = 1'b0; hway = '0; found = 1'b0; pick = '0; best = '0; a = '0;
    for (int w = WAYS - 1; w >= 0; w--)
      if (WCNT_W'(w) < nways_r && vset[w] && rd_r[w].tag == tag_r) begin
        hit = 1'b1; hway = WAY_W'(w);
      end
    for (int w = WAYS - 1; w >= 0; w--)
      if (WCNT_W'(w) < nways_r && !vset[w]) begin
        found = 1'b1; pick = WAY_W'(w);
      end
    if (!found) begin
      for (int w = 0; w < WAYS; w++) begin
        a = cfg.policy ? rd_r[w].use_age : rd_r[w].fill;
        if (WCNT_W'(w) < nways_r && (w == 0 || a > best)) begin
          best = a; pick = WAY_W'(w);
        end
      end
    end
    wr = rd_r;
    for (int w = 0; w < WAYS; w++) begin
      if (WCNT_W'(w) < nways_r && vset[w]) begin
        if (hit) begin
          if (WAY_W'(w) != hway) wr[w].use_age = age_inc(rd_r[w].use_age);
        end else if (WAY_W'(w) != pick) begin
          wr[w].use_age = age_inc(rd_r[w].use_age);
          wr[w].fill = age_inc(rd_r[w].fill);
        end
      end
    end
    if (hit) wr[hway].use_age = '0;
    else begin
      wr[pick].vld = 1'b1;
      wr[pick].tag = tag_r;
      wr[pick].fill = '0;
      wr[pick].use_age = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (clr_busy_r) mem[clr_idx_r] <= '0;
    else if (rd_pend_r) mem[set_r] <= wr;
  end

  assign rsp.done = rd_pend_r;
  assign rsp.hit  = hit;
endmodule

@@ design/three_level_cache_lookup.sv @@
// three_level_cache_lookup: top level, sequencer over three cache levels
// depends on tlc_pkg and tlc_level
`timescale 1ns / 1ps
// One address per transaction is looked up in L1, then L2, then L3. Each
// level keeps its valid bits, tags and ages in one memory read a whole set at
// a time; a probe reads the set into a register, then compares and writes
// back, and the levels are probed one after another until a hit. The result
// register is loaded when an L1 hit, an L2 hit or the end of the L3 probe
// (hit or miss) is seen, and the next transaction can be accepted after it is
// loaded. One item is in flight at a time; a new transaction is accepted only
// once the previous result is taken or is being taken in the same cycle.
// After reset each level clears its memory one set per cycle, so input is
// held off until all three levels have cleared. Configuration writes are
// taken only while no item is in flight and take priority over a waiting
// input.
module three_level_cache_lookup import tlc_pkg::*; #(
  parameter int FIRST_SETS  = 64,
  parameter int SECOND_SETS = 256,
  parameter int THIRD_SETS  = 1024,
  parameter int WAYS        = 8,
  parameter int ADDR_BITS   = 48
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [ADDR_BITS-1:0] in_address,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_hit_level,
  output logic [31:0]          out_first_level_hits,
  output logic [31:0]          out_second_level_hits,
  output logic [31:0]          out_third_level_hits,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_L1   = 4'b0010,
    ST_L2   = 4'b0100,
    ST_L3   = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic [ADDR_BITS-1:0] addr_r;
  logic       policy_r;
  logic [3:0] boff_r, l1s_r, l1w_r, l2s_r, l2w_r, l3s_r, l3w_r;
  logic [31:0] cnt_r [3];
  logic       out_valid_r;
  logic [1:0] lvl_r;

  // configuration registers, writes taken only between items
  assign cfg_ready = (state_r == ST_IDLE);
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= 1'b1; boff_r <= 4'd5;
      l1s_r <= 4'd6; l1w_r <= 4'd2;
      l2s_r <= 4'd8; l2w_r <= 4'd4;
      l3s_r <= 4'd10; l3w_r <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_POLICY:  policy_r <= cfg_data[0];
        REG_BOFF:    boff_r <= cfg_data[3:0];
        REG_L1_SETS: l1s_r <= {1'b0, cfg_data[2:0]};
        REG_L1_WAYS: l1w_r <= cfg_data[3:0];
        REG_L2_SETS: l2s_r <= cfg_data[3:0];
        REG_L2_WAYS: l2w_r <= cfg_data[3:0];
        REG_L3_SETS: l3s_r <= cfg_data[3:0];
        REG_L3_WAYS: l3w_r <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  lvl_rsp_t r1, r2, r3;
  logic init1, init2, init3;
  logic acc, s2, s3, fin;
  logic [1:0] lvl_c;

  assign in_ready = (state_r == ST_IDLE) && init1 && init2 && init3 && !cfg_valid &&
                    !(out_valid_r && !out_ready);
  assign acc = in_valid && in_ready;
  // a miss at L1 or L2 starts the next level
  assign s2 = r1.done && !r1.hit;
  assign s3 = r2.done && !r2.hit;
  assign fin = (r1.done && r1.hit) || (r2.done && r2.hit) || r3.done;

  tlc_level #(.SETS(FIRST_SETS), .WAYS(WAYS), .ADDR_BITS(ADDR_BITS)) u_l1 (
    .clk, .rst_n, .start(acc), .addr(in_address),
    .cfg('{policy_r, boff_r, l1s_r, l1w_r}), .rsp(r1), .init_done(init1));
  tlc_level #(.SETS(SECOND_SETS), .WAYS(WAYS), .ADDR_BITS(ADDR_BITS)) u_l2 (
    .clk, .rst_n, .start(s2), .addr(addr_r),
    .cfg('{policy_r, boff_r, l2s_r, l2w_r}), .rsp(r2), .init_done(init2));
  tlc_level #(.SETS(THIRD_SETS), .WAYS(WAYS), .ADDR_BITS(ADDR_BITS)) u_l3 (
    .clk, .rst_n, .start(s3), .addr(addr_r),
    .cfg('{policy_r, boff_r, l3s_r, l3w_r}), .rsp(r3), .init_done(init3));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (acc) state_nxt = ST_L1;
      ST_L1:   if (r1.done) state_nxt = r1.hit ? ST_IDLE : ST_L2;
      ST_L2:   if (r2.done) state_nxt = r2.hit ? ST_IDLE : ST_L3;
      ST_L3:   if (r3.done) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
    if (r1.done && r1.hit) lvl_c = 2'd0;
    else if (r2.done && r2.hit) lvl_c = 2'd1;
    else if (r3.done && r3.hit) lvl_c = 2'd2;
    else lvl_c = LVL_MISS;
  end

  always_ff @(posedge clk) begin
    if (acc) addr_r <= in_address;
    if (fin) lvl_r <= lvl_c;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) cnt_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      if (fin) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
      if (fin && lvl_c != LVL_MISS && cnt_r[lvl_c] != '1)
        cnt_r[lvl_c] <= cnt_r[lvl_c] + 32'd1;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit_level = lvl_r;
  assign out_first_level_hits = cnt_r[0];
  assign out_second_level_hits = cnt_r[1];
  assign out_third_level_hits = cnt_r[2];

  // result only appears at the end of a probe
  a_fin_busy: assert property (@(posedge clk) disable iff (!rst_n)
    fin |-> state_r != ST_IDLE) else $error("result without item");
  a_no_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    acc |=> state_r == ST_L1) else $error("accept did not start L1");
  a_one_probe: assert property (@(posedge clk) disable iff (!rst_n)
    $countones({r1.done, r2.done, r3.done}) <= 1) else $error("two probes");
endmodule

@@ tb/sv/tb_three_level_cache_lookup.sv @@
// tb_three_level_cache_lookup: self-checking bench for the three level cache lookup
// depends on tlc_pkg and three_level_cache_lookup; drives valid/ready traffic
// and checks every result against an in-bench model of the three tag stores
`timescale 1ns / 1ps
module tb_three_level_cache_lookup;
  import tlc_pkg::*;

  localparam int ADDR_W = 48;
  localparam int WAYS_N = 8;
  localparam int STORE_DEPTH = 1024 * WAYS_N;
  localparam int LEVEL_SETS [3] = '{64, 256, 1024};
  localparam logic [1:0] HIT_L1 = 2'd0;
  localparam logic [1:0] HIT_L2 = 2'd1;
  localparam logic [1:0] HIT_L3 = 2'd2;
  // index past the register list, the block must ignore it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;
  localparam int PHASES = 7;
  localparam int ITEMS_PER_PHASE = 250;

  typedef struct {
    logic [1:0]  level;
    logic [31:0] l1_hits;
    logic [31:0] l2_hits;
    logic [31:0] l3_hits;
  } lookup_result_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    bit                typed;
    logic [1:0]        level;
  } lookup_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [ADDR_W-1:0] in_address = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_hit_level;
  logic [31:0] out_first_level_hits;
  logic [31:0] out_second_level_hits;
  logic [31:0] out_third_level_hits;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  three_level_cache_lookup DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_address(in_address),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_hit_level(out_hit_level),
    .out_first_level_hits(out_first_level_hits),
    .out_second_level_hits(out_second_level_hits),
    .out_third_level_hits(out_third_level_hits),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // model copy of the tag stores, one row per level
  bit                tag_valid [3][STORE_DEPTH];
  logic [ADDR_W-1:0] tag_store [3][STORE_DEPTH];
  logic [15:0]       fill_age  [3][STORE_DEPTH];
  logic [15:0]       use_age   [3][STORE_DEPTH];
  logic [31:0]       hit_count [3];

  // model copy of the configuration
  logic       lru_policy;
  logic [3:0] offset_bits;
  logic [3:0] set_bits_cfg [3];
  logic [3:0] ways_cfg [3];

  lookup_result_t pending_results[$];
  int mismatches = 0;
  bit stimulus_done = 1'b0;

  function automatic logic [15:0] aged(logic [15:0] a);
    return (a == 16'hFFFF) ? a : a + 16'd1;
  endfunction

  // one level probe: true on hit, fills the tag on miss
  function automatic bit probe_level(int lv, logic [ADDR_W-1:0] addr);
    int b;
    int nways;
    int base;
    int pick;
    bit found;
    logic [15:0] best;
    logic [15:0] a;
    logic [63:0] wide;
    logic [ADDR_W-1:0] tag;
    b = set_bits_cfg[lv];
    while (b > 0 && (1 << b) > LEVEL_SETS[lv]) b--;
    wide = {16'd0, addr};
    base = int'((wide >> offset_bits) & ((64'd1 << b) - 64'd1)) * WAYS_N;
    tag = ADDR_W'(wide >> (offset_bits + b));
    nways = (ways_cfg[lv] == 0) ? 1 : ((ways_cfg[lv] > WAYS_N) ? WAYS_N : ways_cfg[lv]);
    for (int w = 0; w < nways; w++) begin
      if (tag_valid[lv][base+w] && tag_store[lv][base+w] == tag) begin
        use_age[lv][base+w] = 16'd0;
        for (int o = 0; o < nways; o++)
          if (o != w && tag_valid[lv][base+o])
            use_age[lv][base+o] = aged(use_age[lv][base+o]);
        return 1'b1;
      end
    end
    pick = 0;
    found = 1'b0;
    for (int w = 0; w < nways && !found; w++) begin
      if (!tag_valid[lv][base+w]) begin
        pick = w;
        found = 1'b1;
      end
    end
    if (!found) begin
      best = 16'd0;
      // strict compare keeps the lowest way on a tie
      for (int w = 0; w < nways; w++) begin
        a = lru_policy ? use_age[lv][base+w] : fill_age[lv][base+w];
        if (w == 0 || a > best) begin
          best = a;
          pick = w;
        end
      end
    end
    tag_valid[lv][base+pick] = 1'b1;
    tag_store[lv][base+pick] = tag;
    fill_age[lv][base+pick] = 16'd0;
    use_age[lv][base+pick] = 16'd0;
    for (int w = 0; w < nways; w++) begin
      if (w != pick && tag_valid[lv][base+w]) begin
        use_age[lv][base+w] = aged(use_age[lv][base+w]);
        fill_age[lv][base+w] = aged(fill_age[lv][base+w]);
      end
    end
    return 1'b0;
  endfunction

  function automatic lookup_result_t predict_lookup(logic [ADDR_W-1:0] addr);
    lookup_result_t r;
    if (probe_level(0, addr)) r.level = HIT_L1;
    else if (probe_level(1, addr)) r.level = HIT_L2;
    else if (probe_level(2, addr)) r.level = HIT_L3;
    else r.level = LVL_MISS;
    if (r.level != LVL_MISS && hit_count[r.level] != 32'hFFFF_FFFF)
      hit_count[r.level]++;
    r.l1_hits = hit_count[0];
    r.l2_hits = hit_count[1];
    r.l3_hits = hit_count[2];
    return r;
  endfunction

  task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH %0t %s: got %0h expected %0h", $time, field, got, want);
    mismatches++;
  endtask

  // result side: the handshake seen at the falling edge completes at the next rise
  always @(negedge clk) begin
    lookup_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected transaction", out_hit_level, 0);
      end else begin
        want = pending_results.pop_front();
        if (out_hit_level !== want.level)
          report_mismatch("hit_level", out_hit_level, want.level);
        if (out_first_level_hits !== want.l1_hits)
          report_mismatch("first_level_hits", out_first_level_hits, want.l1_hits);
        if (out_second_level_hits !== want.l2_hits)
          report_mismatch("second_level_hits", out_second_level_hits, want.l2_hits);
        if (out_third_level_hits !== want.l3_hits)
          report_mismatch("third_level_hits", out_third_level_hits, want.l3_hits);
      end
    end
  end

  // receiver stall pattern: free-running stretches, random stalls, long holds
  int stall_mode = 0;
  int stall_left = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(5, 60);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0: begin
        out_ready <= 1'b1;
      end
      1: begin
        out_ready <= ($urandom_range(0, 3) != 0);
      end
      2: begin
        out_ready <= ($urandom_range(0, 1) != 0);
      end
      default: begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  // cfg_valid stays high into the next call; the caller drops it after the last write
  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    bit taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do begin
      @(negedge clk);
      taken = cfg_valid && cfg_ready;
      @(posedge clk);
    end while (!taken);
    case (idx)
      REG_POLICY: lru_policy = data[0];
      REG_BOFF: offset_bits = data[3:0];
      REG_L1_SETS: set_bits_cfg[0] = {1'b0, data[2:0]};
      REG_L1_WAYS: ways_cfg[0] = data[3:0];
      REG_L2_SETS: set_bits_cfg[1] = data[3:0];
      REG_L2_WAYS: ways_cfg[1] = data[3:0];
      REG_L3_SETS: set_bits_cfg[2] = data[3:0];
      REG_L3_WAYS: ways_cfg[2] = data[3:0];
      default: ;
    endcase
  endtask

  // one lookup transaction; in_valid stays high into the next call when no gap
  task automatic send_lookup(logic [ADDR_W-1:0] addr, bit typed, logic [1:0] level);
    bit taken;
    lookup_result_t r;
    in_valid <= 1'b1;
    in_address <= addr;
    do begin
      @(negedge clk);
      taken = in_valid && in_ready;
      @(posedge clk);
    end while (!taken);
    r = predict_lookup(addr);
    if (typed && r.level !== level)
      report_mismatch("model hit_level", r.level, level);
    if (typed) r.level = level;
    pending_results.push_back(r);
  endtask

  // bursts of back-to-back transactions with random gaps between them
  int burst_left = 0;
  task automatic sender_gap();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 20);
      if ($urandom_range(0, 3) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic drain();
    while (pending_results.size() != 0) @(posedge clk);
    // then leave margin before the next phase
    repeat (12) @(posedge clk);
  endtask

  lookup_row_t directed_rows [] = '{
    '{48'h0000_0000_0000, 1'b1, LVL_MISS},
    '{48'h0000_0000_0000, 1'b1, HIT_L1},
    '{48'hFFFF_FFFF_FFFF, 1'b1, LVL_MISS},
    '{48'hFFFF_FFFF_FFFF, 1'b1, HIT_L1},
    '{48'h0000_0000_001F, 1'b1, HIT_L1},
    '{48'h0000_0000_0020, 1'b1, LVL_MISS},
    '{48'h0000_0000_0800, 1'b0, 2'd0},
    '{48'h0000_0000_1000, 1'b0, 2'd0},
    '{48'h0000_0000_0000, 1'b0, 2'd0},
    '{48'h0000_0000_1800, 1'b0, 2'd0},
    '{48'h0000_0000_0800, 1'b0, 2'd0},
    '{48'h8000_0000_0000, 1'b0, 2'd0},
    '{48'hAAAA_AAAA_AAAA, 1'b0, 2'd0},
    '{48'h5555_5555_5555, 1'b0, 2'd0},
    '{48'h8000_0000_0000, 1'b0, 2'd0},
    '{48'h0000_0000_1000, 1'b0, 2'd0},
    '{48'hAAAA_AAAA_AAAA, 1'b0, 2'd0},
    '{48'h0000_0000_0000, 1'b0, 2'd0},
    '{48'h5555_5555_5555, 1'b0, 2'd0},
    '{48'hFFFF_FFFF_FFE0, 1'b0, 2'd0}
  };

  // per phase: policy, offset, l1 sets, l1 ways, l2 sets, l2 ways, l3 sets, l3 ways
  logic [31:0] phase_regs [PHASES][8] = '{
    '{0, 0, 0, 1, 0, 1, 0, 1},
    '{1, 15, 7, 0, 15, 15, 15, 9},
    '{0, 4, 2, 8, 3, 8, 4, 8},
    '{1, 12, 6, 8, 8, 8, 10, 8},
    '{1, 2, 1, 2, 2, 3, 3, 4},
    '{0, 6, 3, 3, 5, 2, 7, 0},
    '{1, 0, 0, 4, 1, 6, 2, 7}
  };

  logic [ADDR_W-1:0] hot_pool [24];

  initial begin
    logic [ADDR_W-1:0] addr;
    logic [ADDR_W-1:0] shared_low;
    // reset state of the model
    for (int lv = 0; lv < 3; lv++) begin
      hit_count[lv] = '0;
      for (int i = 0; i < STORE_DEPTH; i++) tag_valid[lv][i] = 1'b0;
    end
    lru_policy = 1'b1;
    offset_bits = 4'd5;
    set_bits_cfg = '{4'd6, 4'd8, 4'd10};
    ways_cfg = '{4'd2, 4'd4, 4'd8};

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows run on the reset configuration
    foreach (directed_rows[i])
      send_lookup(directed_rows[i].addr, directed_rows[i].typed, directed_rows[i].level);
    in_valid <= 1'b0;
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      for (int r = 0; r < 8; r++)
        write_register(cfg_reg_t'(r), phase_regs[ph][r] | ($urandom() & 32'hFFFF_FF00));
      write_register(REG_UNUSED, $urandom());
      cfg_valid <= 1'b0;
      // a hot working set, half of it piled into the same sets to force evictions
      shared_low = ADDR_W'($urandom_range(0, 65535));
      foreach (hot_pool[k]) begin
        addr = ADDR_W'({$urandom(), $urandom()});
        if (k % 2 == 0) addr[15:0] = shared_low[15:0];
        hot_pool[k] = addr;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        if ($urandom_range(0, 99) < 85) begin
          addr = hot_pool[$urandom_range(0, 23)];
          addr[3:0] = 4'($urandom());
        end else begin
          addr = ADDR_W'({$urandom(), $urandom()});
        end
        send_lookup(addr, 1'b0, 2'd0);
        sender_gap();
      end
      in_valid <= 1'b0;
      drain();
    end
    stimulus_done = 1'b1;
    if (mismatches == 0)
      $display("three_level_cache_lookup test passed");
    else
      $display("three_level_cache_lookup test failed");
    $finish;
  end

  // watchdog, far above the slowest correct run
  initial begin
    #20ms;
    if (!stimulus_done) begin
      $display("three_level_cache_lookup test failed");
      $finish;
    end
  end
endmodule

@@ filelist.f @@
design/tlc_pkg.sv
design/tlc_level.sv
design/three_level_cache_lookup.sv
tb/sv/tb_three_level_cache_lookup.sv
